// ----- sv/spa_pkg.sv -----
// Shared types and constants for the sparse polynomial adder.
`default_nettype none

package spa_pkg;

  localparam int EXP_W       = 8;
  localparam int COEF_W      = 16;
  localparam int SUM_W       = COEF_W + 1;
  localparam int TERM_W      = EXP_W + COEF_W;
  localparam int MAX_RESULTS = 32;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] OP_STORE_FIRST  = 2'd0;
  localparam logic [1:0] OP_STORE_SECOND = 2'd1;
  localparam logic [1:0] OP_RUN          = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  typedef struct packed {
    logic                     take_a;
    logic                     take_b;
    logic [EXP_W-1:0]         exp;
    logic signed [SUM_W-1:0]  coef;
  } cmp_res_t;

endpackage

`default_nettype wire

// ----- sv/sparse_polynomial_add.sv -----
// Sparse polynomial adder: term buffers, merge sequencer and output register.
// Store word: accepted while s_tready is high, which is whenever no merge runs.
// Run word: the state register enters the merge, then one result per cycle
// through the shared compare/add unit into the output register, slowed only
// by m_tready; s_tready stays low until the last result is loaded.
// Reset clears counts, drop flag and output valid; buffer RAMs are not cleared.
`default_nettype none

module sparse_polynomial_add import spa_pkg::*; #(
  parameter int TERMS_PER_POLY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // term_exponent[7:0], term_coefficient[23:8]
  input  wire logic [1:0]  s_tuser,   // op[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // out_exponent[7:0], out_coefficient[24:8], zero
  output logic             m_tlast,   // run_last
  output logic             m_tuser    // dropped_terms
);

  localparam int CW = $clog2(TERMS_PER_POLY + 1);
  localparam int AW = (TERMS_PER_POLY > 1) ? $clog2(TERMS_PER_POLY) : 1;
  localparam logic [CW-1:0] FULL = CW'(TERMS_PER_POLY);

  state_t                  state, state_next;
  logic [CW-1:0]           cnt_a, cnt_a_next;
  logic [CW-1:0]           cnt_b, cnt_b_next;
  logic [CW-1:0]           idx_a, idx_a_next;
  logic [CW-1:0]           idx_b, idx_b_next;
  logic [RES_CNT_W-1:0]    n_out, n_out_next;
  logic                    overflow, overflow_next;
  logic                    out_valid, out_valid_next;
  logic [EXP_W-1:0]        out_exp;
  logic signed [SUM_W-1:0] out_coef;
  logic                    out_last;
  logic                    out_drop;

  logic              in_acc;
  logic              out_free;
  logic              wr_a, wr_b;
  logic              load_out;
  logic              done;
  logic              has_a, has_b;
  logic [TERM_W-1:0] rd_a, rd_b;
  cmp_res_t          cmp;

  spa_ram #(.WIDTH(TERM_W), .DEPTH(TERMS_PER_POLY)) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (cnt_a[AW-1:0]),
    .wr_data (s_tdata[TERM_W-1:0]),
    .rd_addr (idx_a_next[AW-1:0]),
    .rd_data (rd_a)
  );

  spa_ram #(.WIDTH(TERM_W), .DEPTH(TERMS_PER_POLY)) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (cnt_b[AW-1:0]),
    .wr_data (s_tdata[TERM_W-1:0]),
    .rd_addr (idx_b_next[AW-1:0]),
    .rd_data (rd_b)
  );

  assign has_a = idx_a < cnt_a;
  assign has_b = idx_b < cnt_b;

  spa_cmp u_cmp (
    .a_valid (has_a),
    .a_term  (rd_a),
    .b_valid (has_b),
    .b_term  (rd_b),
    .res     (cmp)
  );

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  always_comb begin
    state_next    = state;
    cnt_a_next    = cnt_a;
    cnt_b_next    = cnt_b;
    idx_a_next    = idx_a;
    idx_b_next    = idx_b;
    n_out_next    = n_out;
    overflow_next = overflow;
    wr_a          = 1'b0;
    wr_b          = 1'b0;
    load_out      = 1'b0;
    done          = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (s_tuser)
            OP_STORE_FIRST: begin
              if (cnt_a != FULL) begin
                wr_a       = 1'b1;
                cnt_a_next = cnt_a + CW'(1);
              end else begin
                overflow_next = 1'b1;
              end
            end
            OP_STORE_SECOND: begin
              if (cnt_b != FULL) begin
                wr_b       = 1'b1;
                cnt_b_next = cnt_b + CW'(1);
              end else begin
                overflow_next = 1'b1;
              end
            end
            OP_RUN: begin
              idx_a_next = '0;
              idx_b_next = '0;
              n_out_next = '0;
              if (cnt_a == '0 && cnt_b == '0) begin
                overflow_next = 1'b0;
              end else begin
                state_next = ST_MERGE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        if (out_free) begin
          load_out   = 1'b1;
          idx_a_next = idx_a + CW'(cmp.take_a);
          idx_b_next = idx_b + CW'(cmp.take_b);
          n_out_next = n_out + RES_CNT_W'(1);
          done = (n_out_next == RES_CNT_W'(MAX_RESULTS)) ||
                 (idx_a_next >= cnt_a && idx_b_next >= cnt_b);
          if (done) begin
            state_next    = ST_IDLE;
            cnt_a_next    = '0;
            cnt_b_next    = '0;
            overflow_next = 1'b0;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt_a     <= '0;
      cnt_b     <= '0;
      idx_a     <= '0;
      idx_b     <= '0;
      n_out     <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt_a     <= cnt_a_next;
      cnt_b     <= cnt_b_next;
      idx_a     <= idx_a_next;
      idx_b     <= idx_b_next;
      n_out     <= n_out_next;
      overflow  <= overflow_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_exp  <= cmp.exp;
      out_coef <= cmp.coef;
      out_last <= done;
      out_drop <= overflow;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_coef, out_exp};
  assign m_tlast  = out_last;
  assign m_tuser  = out_drop;

endmodule

`default_nettype wire

// ----- sv/spa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module spa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                             wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                                  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- sv/spa_cmp.sv -----
// Exponent compare and coefficient add unit for one merge step.
`default_nettype none

module spa_cmp import spa_pkg::*; (
  input  wire logic              a_valid,
  input  wire logic [TERM_W-1:0] a_term,
  input  wire logic              b_valid,
  input  wire logic [TERM_W-1:0] b_term,
  output cmp_res_t               res
);

  logic [EXP_W-1:0]        a_exp;
  logic [EXP_W-1:0]        b_exp;
  logic signed [SUM_W-1:0] a_coef;
  logic signed [SUM_W-1:0] b_coef;

  assign a_exp  = a_term[EXP_W-1:0];
  assign b_exp  = b_term[EXP_W-1:0];
  assign a_coef = SUM_W'($signed(a_term[TERM_W-1:EXP_W]));
  assign b_coef = SUM_W'($signed(b_term[TERM_W-1:EXP_W]));

  always_comb begin
    res.take_a = 1'b0;
    res.take_b = 1'b1;
    res.exp    = b_exp;
    res.coef   = b_coef;
    if (a_valid && b_valid) begin
      if (a_exp == b_exp) begin
        res.take_a = 1'b1;
        res.take_b = 1'b1;
        res.exp    = a_exp;
        res.coef   = a_coef + b_coef;
      end else if (a_exp > b_exp) begin
        res.take_a = 1'b1;
        res.take_b = 1'b0;
        res.exp    = a_exp;
        res.coef   = a_coef;
      end
    end else if (a_valid) begin
      res.take_a = 1'b1;
      res.take_b = 1'b0;
      res.exp    = a_exp;
      res.coef   = a_coef;
    end
  end

endmodule

`default_nettype wire

// ----- verif/tb_sparse_polynomial_add.sv -----
// Self-checking testbench for the sparse polynomial adder: stores, merges and drop flag.
`timescale 1ns / 1ps

module tb_sparse_polynomial_add;
  import spa_pkg::*;

  localparam int          TERMS       = 16;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          DRAIN_WAIT  = 16;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  exp;
    logic [15:0] coef;
    bit          hold;
  } term_word_t;

  typedef struct {
    logic [7:0]         exp;
    logic signed [16:0] coef;
    logic               last;
    logic               dropped;
  } sum_term_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;   // term_exponent[7:0], term_coefficient[23:8]
  logic [1:0]  s_tuser  = '0;   // op[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // out_exponent[7:0], out_coefficient[24:8], zero
  logic        m_tlast;         // run_last
  logic        m_tuser;         // dropped_terms

  term_word_t  pending_words[$];
  sum_term_t   expected_terms[$];
  term_word_t  next_word;
  sum_term_t   got_term;
  sum_term_t   want_term;

  logic [7:0]  poly_a_exp [TERMS];
  logic [15:0] poly_a_coef[TERMS];
  int          poly_a_len   = 0;
  logic [7:0]  poly_b_exp [TERMS];
  logic [15:0] poly_b_coef[TERMS];
  int          poly_b_len   = 0;
  logic        drop_pending = 1'b0;

  bit          word_taken   = 1'b0;
  int          words_sent   = 0;
  int          live_words   = 0;
  int          cycle_count  = 0;
  int          error_count  = 0;
  bit          calm;

  sparse_polynomial_add #(.TERMS_PER_POLY(TERMS)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #4 clk = ~clk;

  assign calm = (words_sent >= 140) && (words_sent < 230);

  function automatic logic signed [16:0] widen(input logic [15:0] c);
    return $signed({c[15], c});
  endfunction

  task automatic absorb_word(input term_word_t w);
    int        i;
    int        j;
    int        n;
    sum_term_t t;
    case (w.op)
      OP_STORE_FIRST: begin
        if (poly_a_len < TERMS) begin
          poly_a_exp[poly_a_len]  = w.exp;
          poly_a_coef[poly_a_len] = w.coef;
          poly_a_len++;
        end else begin
          drop_pending = 1'b1;
        end
      end
      OP_STORE_SECOND: begin
        if (poly_b_len < TERMS) begin
          poly_b_exp[poly_b_len]  = w.exp;
          poly_b_coef[poly_b_len] = w.coef;
          poly_b_len++;
        end else begin
          drop_pending = 1'b1;
        end
      end
      OP_RUN: begin
        i = 0;
        j = 0;
        n = 0;
        while ((i < poly_a_len || j < poly_b_len) && n < MAX_RESULTS) begin
          if (i < poly_a_len && j < poly_b_len && poly_a_exp[i] == poly_b_exp[j]) begin
            t.exp  = poly_a_exp[i];
            t.coef = widen(poly_a_coef[i]) + widen(poly_b_coef[j]);
            i++;
            j++;
          end else if (i < poly_a_len && (j >= poly_b_len || poly_a_exp[i] > poly_b_exp[j]))
          begin
            t.exp  = poly_a_exp[i];
            t.coef = widen(poly_a_coef[i]);
            i++;
          end else begin
            t.exp  = poly_b_exp[j];
            t.coef = widen(poly_b_coef[j]);
            j++;
          end
          t.last    = 1'b0;
          t.dropped = drop_pending;
          expected_terms.push_back(t);
          n++;
        end
        if (n > 0) expected_terms[expected_terms.size() - 1].last = 1'b1;
        poly_a_len   = 0;
        poly_b_len   = 0;
        drop_pending = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic queue_word(input logic [1:0] op, input logic [7:0] exp,
                            input logic [15:0] coef, input bit hold);
    term_word_t w;
    w.op   = op;
    w.exp  = exp;
    w.coef = coef;
    w.hold = hold;
    pending_words.push_back(w);
    if (op != OP_UNUSED) live_words++;
  endtask

  function automatic logic [15:0] rand_coef();
    logic [15:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: v = 16'h7fff;
      1: v = 16'h8000;
      default: ;
    endcase
    return v;
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return TERMS;
    if (r < 14) return $urandom_range(TERMS + 1, TERMS + 4);
    return $urandom_range(0, 6);
  endfunction

  // Drive the stream inputs on the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || word_taken) begin
      if (pending_words.size() != 0 &&
          (!pending_words[0].hold || expected_terms.size() == 0) &&
          (calm || $urandom_range(0, 99) >= 37)) begin
        next_word = pending_words.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {next_word.coef, next_word.exp};
        s_tuser  <= next_word.op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= !rst && (calm || $urandom_range(0, 99) >= 37);
  end

  // Check results and predict on the rising edge.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else if (!rst) begin
      if (m_tvalid && m_tready) begin
        got_term.exp     = m_tdata[7:0];
        got_term.coef    = $signed(m_tdata[24:8]);
        got_term.last    = m_tlast;
        got_term.dropped = m_tuser;
        if (expected_terms.size() == 0) begin
          $error("unexpected result word: exponent %0d coefficient %0d",
                 got_term.exp, got_term.coef);
          error_count++;
        end else begin
          want_term = expected_terms.pop_front();
          if (got_term.exp !== want_term.exp) begin
            $error("out_exponent: expected %0d, got %0d", want_term.exp, got_term.exp);
            error_count++;
          end
          if (got_term.coef !== want_term.coef) begin
            $error("out_coefficient: expected %0d, got %0d", want_term.coef, got_term.coef);
            error_count++;
          end
          if (got_term.last !== want_term.last) begin
            $error("run_last: expected %0b, got %0b", want_term.last, got_term.last);
            error_count++;
          end
          if (got_term.dropped !== want_term.dropped) begin
            $error("dropped_terms: expected %0b, got %0b", want_term.dropped,
                   got_term.dropped);
            error_count++;
          end
        end
      end
      word_taken = s_tvalid && s_tready;
      if (word_taken) begin
        next_word.op   = s_tuser;
        next_word.exp  = s_tdata[7:0];
        next_word.coef = s_tdata[23:8];
        next_word.hold = 1'b0;
        absorb_word(next_word);
        words_sent++;
      end
    end else begin
      word_taken = 1'b0;
    end
  end

  initial begin
    int         size_a;
    int         size_b;
    int         base;
    int         cur;
    int         step_max;
    int         kind;
    bit         hold;
    int         la[$];
    int         lb[$];
    bit         take_a;

    // directed words
    queue_word(OP_RUN, 8'd0, 16'd0, 1'b0);
    queue_word(OP_STORE_FIRST, 8'd255, 16'h7fff, 1'b0);
    queue_word(OP_STORE_FIRST, 8'd0, 16'h8000, 1'b0);
    queue_word(OP_STORE_SECOND, 8'd255, 16'h7fff, 1'b0);
    queue_word(OP_STORE_SECOND, 8'd0, 16'h8000, 1'b0);
    queue_word(OP_RUN, 8'd0, 16'd0, 1'b0);
    queue_word(OP_STORE_FIRST, 8'd10, 16'd5, 1'b1);
    queue_word(OP_STORE_SECOND, 8'd10, -16'sd5, 1'b0);
    queue_word(OP_UNUSED, 8'hff, 16'hffff, 1'b0);
    queue_word(OP_RUN, 8'hff, 16'hffff, 1'b0);
    queue_word(OP_STORE_FIRST, 8'd3, 16'd100, 1'b0);
    queue_word(OP_STORE_FIRST, 8'd9, 16'hffff, 1'b0);
    queue_word(OP_STORE_SECOND, 8'd5, 16'd7, 1'b0);
    queue_word(OP_RUN, 8'd0, 16'd0, 1'b0);
    queue_word(OP_STORE_SECOND, 8'd7, 16'd1, 1'b0);
    queue_word(OP_STORE_SECOND, 8'd2, 16'hfffe, 1'b0);
    queue_word(OP_RUN, 8'd0, 16'd0, 1'b0);
    queue_word(OP_STORE_FIRST, 8'd128, -16'sd300, 1'b0);
    queue_word(OP_RUN, 8'd0, 16'd0, 1'b0);

    // random merge runs, mostly sorted, some broken
    while (live_words < 340) begin
      kind     = $urandom_range(0, 99);
      size_a   = pick_size();
      size_b   = pick_size();
      base     = $urandom_range(30, 255);
      step_max = $urandom_range(0, 1) ? 2 : 10;
      hold     = ($urandom_range(0, 19) == 0);
      la.delete();
      lb.delete();
      cur = base;
      for (int k = 0; k < size_a; k++) begin
        la.push_back(kind < 10 ? $urandom_range(0, 255) : cur);
        cur = cur - $urandom_range(1, step_max);
        if (cur < 0) cur = 0;
      end
      cur = base;
      for (int k = 0; k < size_b; k++) begin
        lb.push_back(kind < 10 ? $urandom_range(0, 255) : cur);
        cur = cur - $urandom_range(1, step_max);
        if (cur < 0) cur = 0;
      end
      while (la.size() != 0 || lb.size() != 0) begin
        if ($urandom_range(0, 19) == 0) begin
          queue_word(OP_UNUSED, 8'($urandom), rand_coef(), 1'b0);
        end
        take_a = (lb.size() == 0) || (la.size() != 0 && $urandom_range(0, 1));
        if (take_a) begin
          queue_word(OP_STORE_FIRST, 8'(la.pop_front()), rand_coef(), hold);
        end else begin
          queue_word(OP_STORE_SECOND, 8'(lb.pop_front()), rand_coef(), hold);
        end
        hold = 1'b0;
      end
      if (kind >= 94) continue;
      queue_word(OP_RUN, 8'($urandom), rand_coef(), hold);
      if (kind < 4) queue_word(OP_RUN, 8'($urandom), rand_coef(), 1'b0);
    end
    queue_word(OP_RUN, 8'd0, 16'd0, 1'b0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_terms.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
